/* rtl/core/dirs_pkg.sv */
package dirs_pkg;

  // Field widths fixed by the interface
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned ModWidth     = 16;
  localparam int unsigned CountCfgW    = 9;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // Parameter defaults
  localparam int unsigned MaxIndicesDef = 256;
  localparam int unsigned IndexWidthDef = 16;

  // Register reset values
  localparam logic [ModWidth-1:0]  ModulusReset = 16'd12323;
  localparam logic [CountCfgW-1:0] CountReset   = 9'd71;

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] CfgModulus     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgCountWanted = 2'd1;

  // Hit flags ORed per group in the first reduction stage
  localparam int unsigned GroupSize = 16;

  typedef struct packed {
    logic shift;   // take neighbor's value
    logic cmp;     // register a fresh compare
  } cell_ctrl_t;

endpackage

/* rtl/core/dirs_cell.sv */
module dirs_cell import dirs_pkg::*; #(
  parameter int unsigned W = IndexWidthDef
) (
  input  logic         clk_i,
  input  cell_ctrl_t   ctrl_i,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  input  logic [W-1:0] cand_i,
  output logic [W-1:0] data_o,
  output logic         hit_o
);

  logic [W-1:0] val_q;
  logic         hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      val_q <= data_i;
    end
    if (ctrl_i.cmp) begin
      hit_q <= valid_i && (val_q == cand_i);
    end
  end

  assign data_o = val_q;
  assign hit_o  = hit_q;

endmodule

/* rtl/core/dirs_match_reduce.sv */
module dirs_match_reduce import dirs_pkg::*; #(
  parameter int unsigned N = MaxIndicesDef
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [N-1:0] hit_i,
  output logic         any_o
);

  localparam int unsigned NumGroups = (N + GroupSize - 1) / GroupSize;
  localparam int unsigned PadN      = NumGroups * GroupSize;

  logic [PadN-1:0]      hit_pad;
  logic [NumGroups-1:0] group_d, group_q;

  assign hit_pad = PadN'(hit_i);

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      group_d[g] = |hit_pad[g*GroupSize +: GroupSize];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      group_q <= group_d;
    end
  end

  assign any_o = |group_q;

endmodule

/* rtl/core/distinct_index_rejection_sampler.sv */
// Distinct index rejection sampler.
// Steps from input accept to result valid: compare, group OR, decide;
//   a full output register can stretch the decide step.
// Flow: one item at a time, a new one accepted only in idle, set by the registered
//   compare chain and its two-stage OR reduction; rejected items also pass every step.
// Reset: async active low; modulus 12323, count_wanted 71, list empty.
module distinct_index_rejection_sampler import dirs_pkg::*; #(
  parameter int unsigned MAX_INDICES = MaxIndicesDef,
  parameter int unsigned INDEX_WIDTH = IndexWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [WordWidth-1:0]    rand_word_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ModWidth-1:0]     sampled_index_o,
  output logic                    run_last_o
);

  // count stays within 0..MAX_INDICES-1; target compare needs room for count_wanted too
  localparam int unsigned CntW = $clog2(MAX_INDICES + 1);
  localparam int unsigned TgtW = (CntW > CountCfgW) ? CntW : CountCfgW;
  localparam logic [ModWidth-1:0] IdxMask = (INDEX_WIDTH >= ModWidth) ?
      {ModWidth{1'b1}} : ModWidth'((32'd1 << INDEX_WIDTH) - 32'd1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CMP    = 2'd1;
  localparam logic [1:0] ST_RED    = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0] state_q, state_d;

  logic [ModWidth-1:0]  modulus_q;
  logic [CountCfgW-1:0] count_wanted_q;
  logic [CntW-1:0]      count_q, count_d;

  logic [ModWidth-1:0] len_mask;
  logic [ModWidth-1:0] cand_d, cand_q;
  logic                in_range_q;

  logic                 out_valid_q;
  logic [ModWidth-1:0]  out_idx_q;
  logic                 out_last_q;

  logic [INDEX_WIDTH-1:0] cand_cell;
  logic [TgtW-1:0]        target;
  logic [TgtW-1:0]        count_inc;
  logic                   any_hit;
  logic                   take;      // candidate is accepted into the list
  logic                   fire;      // result loaded into output register
  logic                   is_last;
  logic                   in_fire;
  cell_ctrl_t             cell_ctrl;

  logic [INDEX_WIDTH-1:0] cell_data [MAX_INDICES];
  logic [MAX_INDICES-1:0] cell_hit;

  // Mask to the bit length of the modulus: smear the top set bit rightward.
  always_comb begin
    len_mask = modulus_q;
    len_mask = len_mask | (len_mask >> 1);
    len_mask = len_mask | (len_mask >> 2);
    len_mask = len_mask | (len_mask >> 4);
    len_mask = len_mask | (len_mask >> 8);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cand_d     = rand_word_i[ModWidth-1:0] & len_mask & IdxMask;

  // Candidate as stored in a cell
  generate
    if (INDEX_WIDTH > ModWidth) begin : g_wide
      assign cand_cell = {{(INDEX_WIDTH - ModWidth){1'b0}}, cand_q};
    end else if (INDEX_WIDTH == ModWidth) begin : g_same
      assign cand_cell = cand_q;
    end else begin : g_narrow
      assign cand_cell = cand_q[INDEX_WIDTH-1:0];
    end
  endgenerate

  // Run target: zero means one, capped at capacity
  always_comb begin
    if (count_wanted_q == '0) begin
      target = TgtW'(1);
    end else if (TgtW'(count_wanted_q) > TgtW'(MAX_INDICES)) begin
      target = TgtW'(MAX_INDICES);
    end else begin
      target = TgtW'(count_wanted_q);
    end
  end

  assign count_inc = TgtW'(count_q) + TgtW'(1);
  assign is_last   = (count_inc >= target);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    take      = 1'b0;
    fire      = 1'b0;
    cell_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cell_ctrl.cmp = 1'b1;
        state_d       = ST_RED;
      end
      ST_RED: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!in_range_q || any_hit) begin
          state_d = ST_IDLE;            // rejected, state unchanged
        end else if (!out_valid_q || out_ready_i) begin
          take            = 1'b1;
          fire            = 1'b1;
          cell_ctrl.shift = 1'b1;
          count_d         = is_last ? '0 : CntW'(count_inc);
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Chain of cells: newest index enters cell 0, older ones move down.
  // Cell k holds a live entry when k < count.
  generate
    for (genvar k = 0; k < MAX_INDICES; k++) begin : g_cell
      logic [INDEX_WIDTH-1:0] nb_data;
      if (k == 0) begin : g_head
        assign nb_data = cand_cell;
      end else begin : g_body
        assign nb_data = cell_data[k-1];
      end
      dirs_cell #(
        .W (INDEX_WIDTH)
      ) u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl),
        .valid_i (count_q > CntW'(k)),
        .data_i  (nb_data),
        .cand_i  (cand_cell),
        .data_o  (cell_data[k]),
        .hit_o   (cell_hit[k])
      );
    end
  endgenerate

  dirs_match_reduce #(
    .N (MAX_INDICES)
  ) u_reduce (
    .clk_i (clk_i),
    .en_i  (state_q == ST_RED),
    .hit_i (cell_hit),
    .any_o (any_hit)
  );

  // Candidate register, loaded at input accept
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cand_q     <= cand_d;
      in_range_q <= (cand_d < modulus_q);
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_idx_q  <= cand_q;
      out_last_q <= is_last;
    end
  end

  // Control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      modulus_q      <= ModulusReset;
      count_wanted_q <= CountReset;
    end else begin
      state_q <= state_d;
      if (take) begin
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgModulus:     modulus_q      <= cfg_data_i;
          CfgCountWanted: count_wanted_q <= cfg_data_i[CountCfgW-1:0];
          default:        ; // unmapped index, ignored
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sampled_index_o = out_idx_q;
  assign run_last_o      = out_last_q;

endmodule
